### rtl/bsfd_pkg.sv
// Shared types and constants for the byte-stuffed frame decoder.
package bsfd_pkg;

    localparam logic [7:0]  ABORT_BYTE        = 8'hFF;
    localparam logic [7:0]  ESC_BYTE          = 8'h7F;
    localparam logic [7:0]  ESC_OFFSET        = 8'd127;
    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'hFFFF;

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_LEAD  = 3'd1,
        PH_LENHI = 3'd2,
        PH_DATA  = 3'd3,
        PH_ESC   = 3'd4,
        PH_CHECK = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_OK    = 2'd1,
        KIND_BAD   = 2'd2,
        KIND_ABORT = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  payload_byte;
        logic [15:0] frame_length;
    } result_t;

endpackage

### rtl/bsfd_in_stage.sv
// Input register stage holding one received byte transaction.
module bsfd_in_stage (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       take,
    output logic       item_valid,
    output logic [7:0] item_byte
);

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;
    logic [7:0] in_byte_next;

    assign s_ready    = !in_valid_reg || take;
    assign item_valid = in_valid_reg;
    assign item_byte  = in_byte_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
            in_byte_next  = s_rx_byte;
        end else if (take) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
        in_byte_reg <= in_byte_next;
    end

endmodule

### rtl/bsfd_decode.sv
// Frame decoding state machine: header, unstuffing, count and checksum.
module bsfd_decode (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [15:0]         cfg_wr_data,
    input  logic                item_valid,
    input  logic [7:0]          rx_byte,
    output logic                res_valid,
    output bsfd_pkg::result_t   res
);

    bsfd_pkg::phase_t phase_reg;
    bsfd_pkg::phase_t phase_next;
    logic [7:0]  length_low_reg;
    logic [7:0]  length_low_next;
    logic [15:0] line_length_reg;
    logic [15:0] line_length_next;
    logic [16:0] line_count_reg;
    logic [16:0] line_count_next;
    logic [15:0] payload_count_reg;
    logic [15:0] payload_count_next;
    logic [7:0]  running_xor_reg;
    logic [7:0]  running_xor_next;
    logic [15:0] max_payload_reg;

    logic        is_abort;
    logic        esc_phase;
    logic [7:0]  dec_value;
    logic [16:0] line_count_sum;
    logic        show;
    logic [15:0] hdr_v;
    logic [15:0] hdr_len;

    assign is_abort       = (rx_byte == bsfd_pkg::ABORT_BYTE);
    assign esc_phase      = (phase_reg == bsfd_pkg::PH_ESC);
    assign dec_value      = esc_phase ? (rx_byte + bsfd_pkg::ESC_OFFSET) : rx_byte;
    assign line_count_sum = line_count_reg + (esc_phase ? 17'd2 : 17'd1);
    assign show           = (payload_count_reg < max_payload_reg);
    assign hdr_v          = {rx_byte, length_low_reg};
    assign hdr_len        = hdr_v - {8'd0, hdr_v[15:8]};

    always_comb begin
        phase_next         = phase_reg;
        length_low_next    = length_low_reg;
        line_length_next   = line_length_reg;
        line_count_next    = line_count_reg;
        payload_count_next = payload_count_reg;
        running_xor_next   = running_xor_reg;
        if (item_valid) begin
            if (is_abort) begin
                phase_next = (phase_reg == bsfd_pkg::PH_HUNT) ? bsfd_pkg::PH_LEAD
                                                              : bsfd_pkg::PH_HUNT;
            end else begin
                case (phase_reg)
                    bsfd_pkg::PH_LENHI: begin
                        line_length_next   = hdr_len;
                        line_count_next    = 17'd0;
                        payload_count_next = 16'd0;
                        running_xor_next   = 8'd0;
                        phase_next = (hdr_len == 16'd0) ? bsfd_pkg::PH_HUNT
                                                        : bsfd_pkg::PH_DATA;
                    end
                    bsfd_pkg::PH_DATA, bsfd_pkg::PH_ESC: begin
                        if (!esc_phase && rx_byte == bsfd_pkg::ESC_BYTE) begin
                            phase_next = bsfd_pkg::PH_ESC;
                        end else begin
                            running_xor_next   = running_xor_reg ^ dec_value;
                            payload_count_next = payload_count_reg + 16'd1;
                            line_count_next    = line_count_sum;
                            phase_next = (line_count_sum >= {1'b0, line_length_reg})
                                         ? bsfd_pkg::PH_CHECK : bsfd_pkg::PH_DATA;
                        end
                    end
                    bsfd_pkg::PH_CHECK: begin
                        phase_next = bsfd_pkg::PH_HUNT;
                    end
                    default: begin
                        length_low_next = rx_byte;
                        phase_next      = bsfd_pkg::PH_LENHI;
                    end
                endcase
            end
        end
    end

    always_comb begin
        res_valid        = 1'b0;
        res.kind         = bsfd_pkg::KIND_BYTE;
        res.payload_byte = 8'd0;
        res.frame_length = 16'd0;
        if (item_valid) begin
            if (is_abort) begin
                res_valid = (phase_reg != bsfd_pkg::PH_HUNT);
                res.kind  = bsfd_pkg::KIND_ABORT;
            end else begin
                case (phase_reg)
                    bsfd_pkg::PH_DATA, bsfd_pkg::PH_ESC: begin
                        if (esc_phase || rx_byte != bsfd_pkg::ESC_BYTE) begin
                            res_valid        = show;
                            res.payload_byte = dec_value;
                        end
                    end
                    bsfd_pkg::PH_CHECK: begin
                        res_valid = 1'b1;
                        if (rx_byte == running_xor_reg) begin
                            res.kind         = bsfd_pkg::KIND_OK;
                            res.frame_length = payload_count_reg;
                        end else begin
                            res.kind = bsfd_pkg::KIND_BAD;
                        end
                    end
                    default: begin
                        res_valid = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= bsfd_pkg::PH_HUNT;
            length_low_reg    <= 8'd0;
            line_length_reg   <= 16'd0;
            line_count_reg    <= 17'd0;
            payload_count_reg <= 16'd0;
            running_xor_reg   <= 8'd0;
            max_payload_reg   <= bsfd_pkg::MAX_PAYLOAD_RESET;
        end else begin
            phase_reg         <= phase_next;
            length_low_reg    <= length_low_next;
            line_length_reg   <= line_length_next;
            line_count_reg    <= line_count_next;
            payload_count_reg <= payload_count_next;
            running_xor_reg   <= running_xor_next;
            if (cfg_wr_en) begin
                max_payload_reg <= cfg_wr_data;
            end
        end
    end

endmodule

### rtl/bsfd_out_stage.sv
// Result register stage driving the output transaction.
module bsfd_out_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  bsfd_pkg::result_t   res,
    output logic                free,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_result_kind,
    output logic [7:0]          m_payload_byte,
    output logic [15:0]         m_frame_length
);

    logic              out_valid_reg;
    logic              out_valid_next;
    bsfd_pkg::result_t out_res_reg;
    bsfd_pkg::result_t out_res_next;

    assign free           = !out_valid_reg || m_ready;
    assign m_valid        = out_valid_reg;
    assign m_result_kind  = out_res_reg.kind;
    assign m_payload_byte = out_res_reg.payload_byte;
    assign m_frame_length = out_res_reg.frame_length;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (load) begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        out_res_reg <= out_res_next;
    end

endmodule

### rtl/byte_stuffed_frame_decoder_core.sv
// Top level of the byte-stuffed frame decoder.
// Accepts one line byte per cycle and returns at most one result per byte: a decoded
// payload byte, a frame accepted status with the payload count, a checksum mismatch
// or an abort. A byte is held in the input register until the output register is free;
// the frame state is then updated and the result loaded at the same edge, so m_valid
// rises in the cycle after the byte is taken. Throughput is one byte per cycle, as the
// frame state is updated as each byte is taken; it drops only while the m_ side stalls.
// max_payload is written through cfg_wr_en/cfg_wr_data and resets to 65535.
module byte_stuffed_frame_decoder_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_result_kind,
    output logic [7:0]  m_payload_byte,
    output logic [15:0] m_frame_length
);

    logic              item_valid;
    logic [7:0]        item_byte;
    logic              out_free;
    logic              take;
    logic              res_valid;
    bsfd_pkg::result_t res;

    assign take = item_valid && out_free;

    bsfd_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .take       (take),
        .item_valid (item_valid),
        .item_byte  (item_byte)
    );

    bsfd_decode u_decode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_valid  (take),
        .rx_byte     (item_byte),
        .res_valid   (res_valid),
        .res         (res)
    );

    bsfd_out_stage u_out_stage (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (res_valid),
        .res            (res),
        .free           (out_free),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_kind  (m_result_kind),
        .m_payload_byte (m_payload_byte),
        .m_frame_length (m_frame_length)
    );

endmodule

### tb/sv/byte_stuffed_frame_decoder_core_tb.sv
// Self-checking testbench for byte_stuffed_frame_decoder_core: random and directed frames.
module byte_stuffed_frame_decoder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_LIMIT = 200000;
    localparam logic [7:0] OPENING [28] = '{
        bsfd_pkg::ABORT_BYTE, 8'h01, 8'h00, 8'hFE, 8'hFE,
        8'h00, 8'h00,
        8'h01, 8'h00, bsfd_pkg::ESC_BYTE, 8'h80, bsfd_pkg::ABORT_BYTE,
        8'h02, 8'h00, 8'h41, bsfd_pkg::ABORT_BYTE,
        8'h01, 8'h00, 8'h55, 8'h00,
        8'h03, bsfd_pkg::ABORT_BYTE,
        8'h01, 8'h00, bsfd_pkg::ESC_BYTE, bsfd_pkg::ABORT_BYTE,
        bsfd_pkg::ABORT_BYTE, bsfd_pkg::ABORT_BYTE
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_result_kind;
    logic [7:0]  m_payload_byte;
    logic [15:0] m_frame_length;

    logic [7:0]        byte_q[$];
    bsfd_pkg::result_t expected_q[$];

    // decoder state as predicted
    logic [15:0]      cap = bsfd_pkg::MAX_PAYLOAD_RESET;
    bsfd_pkg::phase_t dec_phase = bsfd_pkg::PH_HUNT;
    logic [7:0]       len_lo = '0;
    logic [15:0]      line_len = '0;
    logic [16:0]      units_used = '0;
    logic [15:0]      byte_count = '0;
    logic [7:0]       xor_acc = '0;

    bit send_calm = 1'b0;
    bit recv_calm = 1'b0;
    int send_gap = 0;
    int recv_wait = 0;
    bit long_hold_done = 1'b0;
    int results_seen = 0;
    int mismatches = 0;
    int cycle_no = 0;

    byte_stuffed_frame_decoder_core DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_byte     (s_rx_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_kind (m_result_kind),
        .m_payload_byte(m_payload_byte),
        .m_frame_length(m_frame_length)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("[cycle %0d] mismatch: %s", cycle_no, what);
    endtask

    function automatic void take_byte(input logic [7:0] v, input logic [1:0] units);
        logic shown;
        shown = byte_count < cap;
        xor_acc ^= v;
        byte_count++;
        units_used += units;
        dec_phase = (units_used >= {1'b0, line_len}) ? bsfd_pkg::PH_CHECK
                                                     : bsfd_pkg::PH_DATA;
        if (shown)
            expected_q.push_back(bsfd_pkg::result_t'{bsfd_pkg::KIND_BYTE, v, 16'h0000});
    endfunction

    function automatic void decode_byte(input logic [7:0] b);
        logic [15:0] hdr;
        if (b == bsfd_pkg::ABORT_BYTE) begin
            if (dec_phase == bsfd_pkg::PH_HUNT) begin
                dec_phase = bsfd_pkg::PH_LEAD;
            end else begin
                dec_phase = bsfd_pkg::PH_HUNT;
                expected_q.push_back(
                    bsfd_pkg::result_t'{bsfd_pkg::KIND_ABORT, 8'h00, 16'h0000});
            end
            return;
        end
        case (dec_phase)
            bsfd_pkg::PH_HUNT, bsfd_pkg::PH_LEAD: begin
                len_lo = b;
                dec_phase = bsfd_pkg::PH_LENHI;
            end
            bsfd_pkg::PH_LENHI: begin
                hdr = {b, len_lo};
                line_len = hdr - {8'h00, hdr[15:8]};
                units_used = '0;
                byte_count = '0;
                xor_acc = '0;
                dec_phase = (line_len == 0) ? bsfd_pkg::PH_HUNT : bsfd_pkg::PH_DATA;
            end
            bsfd_pkg::PH_DATA: begin
                if (b == bsfd_pkg::ESC_BYTE)
                    dec_phase = bsfd_pkg::PH_ESC;
                else
                    take_byte(b, 2'd1);
            end
            bsfd_pkg::PH_ESC: take_byte(b + bsfd_pkg::ESC_OFFSET, 2'd2);
            default: begin
                dec_phase = bsfd_pkg::PH_HUNT;
                if (b == xor_acc)
                    expected_q.push_back(
                        bsfd_pkg::result_t'{bsfd_pkg::KIND_OK, 8'h00, byte_count});
                else
                    expected_q.push_back(
                        bsfd_pkg::result_t'{bsfd_pkg::KIND_BAD, 8'h00, 16'h0000});
            end
        endcase
    endfunction

    function automatic logic [15:0] header_for(input logic [15:0] len);
        logic [15:0] v;
        for (int hi = 0; hi < 256; hi++) begin
            v = len + 16'(hi);
            if (v[7:0] != bsfd_pkg::ABORT_BYTE && v - {8'h00, v[15:8]} == len)
                return v;
        end
        return len;
    endfunction

    task automatic queue_frame(input int n, input bit lead, input bit bad_sum, input bit cut,
                               input bit short_len);
        logic [7:0]  d, sum, line[$];
        logic [15:0] hdr;
        int          units, keep;
        sum = '0;
        units = 0;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0: d = bsfd_pkg::ESC_BYTE;
                1: d = bsfd_pkg::ABORT_BYTE;
                2: d = 8'h7E;
                default: d = 8'($urandom_range(0, 255));
            endcase
            if (short_len && i == n - 1 && d == 8'h7E)
                d = 8'h00;
            sum ^= d;
            if (d == bsfd_pkg::ESC_BYTE || d == bsfd_pkg::ABORT_BYTE ||
                (short_len && i == n - 1) ||
                (d != 8'h7E && $urandom_range(0, 7) == 0)) begin
                line.push_back(bsfd_pkg::ESC_BYTE);
                line.push_back(d - bsfd_pkg::ESC_OFFSET);
                units += 2;
            end else begin
                line.push_back(d);
                units += 1;
            end
        end
        // escape in the last line unit: declare one unit short
        hdr = header_for(16'(short_len ? units - 1 : units));
        if (lead)
            byte_q.push_back(bsfd_pkg::ABORT_BYTE);
        byte_q.push_back(hdr[7:0]);
        byte_q.push_back(hdr[15:8]);
        if (n == 0)
            return;
        if (cut) begin
            keep = $urandom_range(0, line.size() - 1);
            for (int i = 0; i < keep; i++)
                byte_q.push_back(line[i]);
            byte_q.push_back(bsfd_pkg::ABORT_BYTE);
        end else begin
            foreach (line[i])
                byte_q.push_back(line[i]);
            byte_q.push_back(bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum);
        end
    endtask

    task automatic add_traffic(input int budget);
        int stop, size;
        bit lead;
        stop = byte_q.size() + budget;
        while (byte_q.size() < stop) begin
            size = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 12);
            lead = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 9))
                0: begin
                    repeat ($urandom_range(1, 6))
                        byte_q.push_back(8'($urandom_range(0, 255)));
                    byte_q.push_back(bsfd_pkg::ABORT_BYTE);
                end
                1: queue_frame(size, lead, 1'b0, size != 0, 1'b0);
                2: queue_frame(size, lead, 1'b1, 1'b0, 1'b0);
                3: queue_frame($urandom_range(1, 8), lead, 1'b0, 1'b0, 1'b1);
                default: queue_frame(size, lead, 1'b0, 1'b0, 1'b0);
            endcase
        end
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        while (byte_q.size() != 0 || s_valid || expected_q.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic start_phase(input logic [15:0] limit);
        wait_idle();
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= limit;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cap = limit;
        send_calm = ($urandom_range(0, 3) == 0);
        recv_calm = ($urandom_range(0, 3) == 0);
        @(negedge aclk);
    endtask

    always @(posedge aclk) begin : feed
        logic offering;
        if (aresetn) begin
            offering = s_valid;
            if (s_valid && s_ready) begin
                decode_byte(s_rx_byte);
                offering = 1'b0;
                send_gap = send_calm ? 0 : $urandom_range(0, 10);
            end
            if (!offering) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (byte_q.size() != 0) begin
                    s_rx_byte <= byte_q.pop_front();
                    offering = 1'b1;
                end
            end
            s_valid <= offering;
        end
    end

    always @(posedge aclk) begin : result_check
        bsfd_pkg::result_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_q.size() == 0) begin
                    flag_mismatch("result transaction with nothing expected");
                end else begin
                    want = expected_q.pop_front();
                    if (m_result_kind !== want.kind)
                        flag_mismatch($sformatf("result_kind %0d, expected %0d",
                                                m_result_kind, want.kind));
                    if (m_payload_byte !== want.payload_byte)
                        flag_mismatch($sformatf("payload_byte %0h, expected %0h",
                                                m_payload_byte, want.payload_byte));
                    if (m_frame_length !== want.frame_length)
                        flag_mismatch($sformatf("frame_length %0d, expected %0d",
                                                m_frame_length, want.frame_length));
                end
                recv_wait = recv_calm ? 0 : $urandom_range(0, 10);
                // hold off long enough to back the decoder up
                if (!long_hold_done && results_seen >= 150) begin
                    recv_wait = 300;
                    long_hold_done = 1'b1;
                end
            end else if (recv_wait > 0) begin
                recv_wait--;
            end
            m_ready <= (recv_wait == 0);
        end
    end

    always @(posedge aclk) begin
        cycle_no++;
        if (cycle_no > RUN_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (OPENING[i])
            byte_q.push_back(OPENING[i]);

        start_phase(16'd0);
        add_traffic(20);
        start_phase(16'd1);
        add_traffic(25);
        start_phase(16'd3);
        add_traffic(30);
        start_phase(bsfd_pkg::MAX_PAYLOAD_RESET);
        add_traffic(35);
        start_phase(16'd200);
        queue_frame(220, 1'b1, 1'b0, 1'b0, 1'b0);
        add_traffic(15);
        start_phase(16'($urandom_range(2, 20)));
        add_traffic(30);

        wait_idle();
        repeat (6) @(posedge aclk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### files.f
rtl/bsfd_pkg.sv
rtl/bsfd_in_stage.sv
rtl/bsfd_decode.sv
rtl/bsfd_out_stage.sv
rtl/byte_stuffed_frame_decoder_core.sv
tb/sv/byte_stuffed_frame_decoder_core_tb.sv
